// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the SHA-1 hasher RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check that is switched off while reset is asserted.
`define SHA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds during reset.
`define SHA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHA_ASSERT(lbl, clk, rstn, prop, msg)
`define SHA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/sha1sh_pkg.sv =====
// Types and constants of the SHA-1 stream hasher.
// Used by the controller, the datapath and the top level; no dependencies.
package sha1sh_pkg;

  localparam int CHAIN_WORDS = 5;
  localparam int BLK_WORDS   = 16;
  localparam int POS_W       = 6;
  localparam int RND_W       = 7;
  localparam int IDX_W       = 3;
  localparam int CNT_W       = 61;

  localparam int ROUNDS      = 80;
  localparam int LAST_ROUND  = ROUNDS - 1;
  localparam int SCHED_INIT  = 16;
  localparam int RND_STAGE1  = 20;
  localparam int RND_STAGE2  = 40;
  localparam int RND_STAGE3  = 60;

  localparam int BLK_LAST_POS = 63;
  localparam int PAD_LEN_POS  = 56;
  localparam int LAST_IDX     = CHAIN_WORDS - 1;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] IV [CHAIN_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef struct packed {
    logic             absorb;
    logic             pad;
    logic             load_len;
    logic             clear;
    logic             rnd_init;
    logic             rnd_step;
    logic [RND_W-1:0] rnd;
    logic             chain_add;
    logic             chain_init;
    logic [IDX_W-1:0] out_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
  } dp_stat_t;

endpackage

// ===== hdl/sha1sh_ctrl.sv =====
// Controller of the SHA-1 hasher: sequences absorb, padding, rounds and output.
// Depends on sha1sh_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sha1sh_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_byte_present,
  input  logic                in_end,
  output logic                out_valid,
  input  logic                out_stall,
  output sha1sh_pkg::dp_cmd_t cmd,
  input  sha1sh_pkg::dp_stat_t stat
);
  import sha1sh_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_LEN, ST_LOAD, ST_ROUND, ST_ADD, ST_OUT
  } state_t;

  typedef enum logic [1:0] {PH_DATA, PH_PAD1, PH_LAST} phase_t;

  state_t           state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  logic             eom_r, eom_nxt;
  logic [RND_W-1:0] round_r, round_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             in_acc;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign in_acc    = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    eom_nxt   = eom_r;
    round_nxt = round_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          eom_nxt   = in_end;
          phase_nxt = PH_DATA;
          // A byte landing in the last slot fills the block first.
          if (in_byte_present && stat.pos == POS_W'(BLK_LAST_POS)) begin
            state_nxt = ST_LOAD;
          end else if (in_end) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // No room for the length: the padded block goes out on its own.
        if (stat.pos >= POS_W'(PAD_LEN_POS)) begin
          state_nxt = ST_LOAD;
          phase_nxt = PH_PAD1;
        end else begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        state_nxt = ST_LOAD;
        phase_nxt = PH_LAST;
      end
      ST_LOAD: begin
        state_nxt = ST_ROUND;
        round_nxt = '0;
      end
      ST_ROUND: begin
        if (round_r == RND_W'(LAST_ROUND)) begin
          state_nxt = ST_ADD;
        end else begin
          round_nxt = round_r + 1'b1;
        end
      end
      ST_ADD: begin
        unique case (phase_r)
          PH_DATA: state_nxt = eom_r ? ST_PAD : ST_IDLE;
          PH_PAD1: state_nxt = ST_LEN;
          PH_LAST: begin
            state_nxt = ST_OUT;
            idx_nxt   = '0;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_OUT: begin
        if (!out_stall) begin
          if (idx_r == IDX_W'(LAST_IDX)) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.absorb     = in_acc && in_byte_present;
    cmd.pad        = (state_r == ST_PAD);
    cmd.load_len   = (state_r == ST_LEN);
    cmd.clear      = (state_r == ST_LEN) && (phase_r == PH_PAD1);
    cmd.rnd_init   = (state_r == ST_LOAD);
    cmd.rnd_step   = (state_r == ST_ROUND);
    cmd.rnd        = round_r;
    cmd.chain_add  = (state_r == ST_ADD);
    cmd.chain_init = (state_r == ST_OUT) && !out_stall && (idx_r == IDX_W'(LAST_IDX));
    cmd.out_idx    = idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_DATA;
      eom_r   <= 1'b0;
      round_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      eom_r   <= eom_nxt;
      round_r <= round_nxt;
      idx_r   <= idx_nxt;
    end
  end

  `SHA_ASSERT(a_no_out_when_open, clk, rst_n, !in_stall |-> !out_valid, "output valid while taking input")
  `SHA_ASSERT(a_round_range, clk, rst_n, (state_r == ST_ROUND) |-> (round_r <= RND_W'(LAST_ROUND)), "round counter out of range")
  `SHA_ASSERT(a_add_after_rounds, clk, rst_n, (state_r == ST_ADD) |-> ($past(state_r) == ST_ROUND && $past(round_r) == RND_W'(LAST_ROUND)), "chain add without full round sequence")
  `SHA_ASSERT(a_idle_after_digest, clk, rst_n, (out_valid && !out_stall && idx_r == IDX_W'(LAST_IDX)) |=> !in_stall, "not ready after last digest word")

endmodule

// ===== hdl/sha1sh_dp.sv =====
// Datapath of the SHA-1 hasher: message block, schedule, round logic, chain.
// Depends on sha1sh_pkg.
module sha1sh_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha1sh_pkg::dp_cmd_t  cmd,
  output sha1sh_pkg::dp_stat_t stat,
  input  logic [7:0]           in_byte,
  output logic [31:0]          digest_word
);
  import sha1sh_pkg::*;

  logic [31:0]      chain_r [CHAIN_WORDS];
  logic [31:0]      chain_nxt [CHAIN_WORDS];
  logic [31:0]      blk_r [BLK_WORDS];
  logic [31:0]      blk_nxt [BLK_WORDS];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      a_r, b_r, c_r, d_r, e_r;
  logic [31:0]      a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [POS_W-1:0] pos;
  logic [63:0]      bit_len;
  logic [31:0]      f, k, w, w_x, t;

  assign pos         = count_r[POS_W-1:0];
  assign stat.pos    = pos;
  assign bit_len     = {count_r, 3'b000};
  assign digest_word = chain_r[cmd.out_idx];

  // Round function and constant by stage.
  always_comb begin
    if (cmd.rnd < RND_W'(RND_STAGE1)) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = K0;
    end else if (cmd.rnd < RND_W'(RND_STAGE2)) begin
      f = b_r ^ c_r ^ d_r;
      k = K1;
    end else if (cmd.rnd < RND_W'(RND_STAGE3)) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = K2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = K3;
    end
  end

  // The block doubles as the 16-word schedule window; word 0 is the oldest.
  assign w_x = blk_r[13] ^ blk_r[8] ^ blk_r[2] ^ blk_r[0];
  assign w   = (cmd.rnd < RND_W'(SCHED_INIT)) ? blk_r[0] : {w_x[30:0], w_x[31]};
  assign t   = {a_r[26:0], a_r[31:27]} + f + e_r + k + w;

  always_comb begin
    logic [POS_W-1:0] p;
    p = '0;
    blk_nxt = blk_r;
    if (cmd.absorb) begin
      blk_nxt[pos[5:2]][{~pos[1:0], 3'b000} +: 8] = in_byte;
    end
    if (cmd.pad) begin
      for (int i = 0; i < BLK_WORDS; i++) begin
        for (int j = 0; j < 4; j++) begin
          p = POS_W'(i * 4 + j);
          if (p == pos) begin
            blk_nxt[i][(3 - j) * 8 +: 8] = PAD_BYTE;
          end else if (p > pos) begin
            blk_nxt[i][(3 - j) * 8 +: 8] = 8'h00;
          end
        end
      end
    end
    if (cmd.load_len) begin
      if (cmd.clear) begin
        for (int i = 0; i < BLK_WORDS - 2; i++) begin
          blk_nxt[i] = '0;
        end
      end
      blk_nxt[BLK_WORDS-2] = bit_len[63:32];
      blk_nxt[BLK_WORDS-1] = bit_len[31:0];
    end
    if (cmd.rnd_step) begin
      for (int i = 0; i < BLK_WORDS - 1; i++) begin
        blk_nxt[i] = blk_r[i + 1];
      end
      blk_nxt[BLK_WORDS-1] = w;
    end
  end

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    d_nxt = d_r;
    e_nxt = e_r;
    if (cmd.rnd_init) begin
      a_nxt = chain_r[0];
      b_nxt = chain_r[1];
      c_nxt = chain_r[2];
      d_nxt = chain_r[3];
      e_nxt = chain_r[4];
    end else if (cmd.rnd_step) begin
      a_nxt = t;
      b_nxt = a_r;
      c_nxt = {b_r[1:0], b_r[31:2]};
      d_nxt = c_r;
      e_nxt = d_r;
    end
  end

  always_comb begin
    chain_nxt = chain_r;
    count_nxt = count_r;
    if (cmd.absorb) begin
      count_nxt = count_r + 1'b1;
    end
    if (cmd.chain_add) begin
      chain_nxt[0] = chain_r[0] + a_r;
      chain_nxt[1] = chain_r[1] + b_r;
      chain_nxt[2] = chain_r[2] + c_r;
      chain_nxt[3] = chain_r[3] + d_r;
      chain_nxt[4] = chain_r[4] + e_r;
    end
    if (cmd.chain_init) begin
      chain_nxt = IV;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= IV;
      count_r <= '0;
    end else begin
      chain_r <= chain_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    e_r   <= e_nxt;
  end

endmodule

// ===== hdl/sha1_stream_hasher_core.sv =====
// SHA-1 over a byte stream. An item without a block boundary or end does not hold the input.
// A byte that fills the 64-byte block holds input while the block is compressed (80 rounds, one per cycle).
// An end item holds input through padding, compression (twice when padding spills into a second block)
// and the output of the 5 digest words; sustained throughput is set by the single round unit.
// Reset (synchronous, rst_n low) clears control, the byte count and loads the initial chain.
module sha1_stream_hasher_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sha1sh_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sha1sh_pkg::out_item_t out_item
);
  import sha1sh_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [31:0] digest_word;

  sha1sh_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_present (in_item.byte_present),
    .in_end          (in_item.end_of_message),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cmd             (cmd),
    .stat            (stat)
  );

  sha1sh_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_byte     (in_item.data_byte),
    .digest_word (digest_word)
  );

  assign out_item.digest_word = digest_word;
  assign out_item.word_index  = cmd.out_idx;
  assign out_item.last_word   = (cmd.out_idx == IDX_W'(LAST_IDX));

endmodule

// ===== tb/tb_sha1_stream_hasher_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sha1_stream_hasher_core: a scoreboard class with its own SHA-1
// predictor checks every digest word under random gaps and stalls. Needs sha1sh_pkg and the core.

module tb_sha1_stream_hasher_core;
  import sha1sh_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 230;
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_REPORTS  = 10;

  class digest_scoreboard;
    logic [31:0] chain [5];
    logic [31:0] blk [16];
    logic [60:0] nbytes;
    out_item_t   expected_words [$];
    int          mismatches;
    int          checked;
    int          messages;

    function new();
      mismatches = 0;
      checked = 0;
      messages = 0;
      foreach (blk[i]) blk[i] = '0;
      restart();
    endfunction

    function void restart();
      chain[0] = 32'h67452301;
      chain[1] = 32'hEFCDAB89;
      chain[2] = 32'h98BADCFE;
      chain[3] = 32'h10325476;
      chain[4] = 32'hC3D2E1F0;
      nbytes = '0;
    endfunction

    function logic [31:0] rotl(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, t;
      foreach (w[i]) w[i] = blk[i];
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int r = 0; r < 80; r++) begin
        // The schedule is kept as a 16-word circular window.
        if (r >= 16)
          w[r % 16] = rotl(w[(r - 3) % 16] ^ w[(r - 8) % 16] ^ w[(r - 14) % 16] ^ w[r % 16], 1);
        if (r < 20) begin
          f = (b & c) | (~b & d);
          k = 32'h5A827999;
        end else if (r < 40) begin
          f = b ^ c ^ d;
          k = 32'h6ED9EBA1;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = 32'h8F1BBCDC;
        end else begin
          f = b ^ c ^ d;
          k = 32'hCA62C1D6;
        end
        t = rotl(a, 5) + f + e + k + w[r % 16];
        e = d;
        d = c;
        c = rotl(b, 30);
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    function void put_byte(logic [5:0] pos, logic [7:0] value);
      blk[pos[5:2]][8 * (3 - pos[1:0]) +: 8] = value;
    endfunction

    // Notes one accepted input item and queues the digest words it produces.
    function void absorb_item(in_item_t it);
      logic [5:0]  pos;
      logic [63:0] bit_len;
      out_item_t   word;
      if (it.byte_present) begin
        pos = nbytes[5:0];
        put_byte(pos, it.data_byte);
        nbytes = nbytes + 61'd1;
        if (pos == 6'd63) compress();
      end
      if (!it.end_of_message) return;
      pos = nbytes[5:0];
      put_byte(pos, 8'h80);
      for (int i = int'(pos) + 1; i < 64; i++) put_byte(6'(i), 8'h00);
      // No room left for the length field, so the padding spills into a second block.
      if (pos >= 6'd56) begin
        compress();
        foreach (blk[i]) blk[i] = '0;
      end
      bit_len = {nbytes, 3'b000};
      blk[14] = bit_len[63:32];
      blk[15] = bit_len[31:0];
      compress();
      for (int i = 0; i < 5; i++) begin
        word.digest_word = chain[i];
        word.word_index = 3'(i);
        word.last_word = (i == 4);
        expected_words.push_back(word);
      end
      messages++;
      restart();
    endfunction

    function void report(string what, out_item_t want, out_item_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] %s: expected word %h index %0d last %b, got word %h index %0d last %b",
                 $time, what, want.digest_word, want.word_index, want.last_word,
                 got.digest_word, got.word_index, got.last_word);
    endfunction

    function void check_word(out_item_t got);
      out_item_t want;
      if (expected_words.size() == 0) begin
        report("digest word with none outstanding", '0, got);
        return;
      end
      want = expected_words.pop_front();
      checked++;
      if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
          got.last_word !== want.last_word)
        report("digest word mismatch", want, got);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  digest_scoreboard digests = new();
  int data_items = 0;
  int noop_items = 0;
  int cycles;
  int input_stall_cycles;
  bit hold_req = 1'b0;
  bit no_idle = 1'b0;

  sha1_stream_hasher_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Lengths cluster around the padding boundaries, where the extra compression appears.
  function automatic int pick_length();
    int r;
    int boundary_lens [6] = '{55, 56, 57, 63, 64, 65};
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 8);
    if (r < 75) return boundary_lens[$urandom_range(0, 5)];
    return $urandom_range(9, 40);
  endfunction

  task automatic send_item(logic [7:0] data, bit present, bit eom);
    in_item_t it;
    int       gap;
    it.data_byte = data;
    it.byte_present = present;
    it.end_of_message = eom;
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    digests.absorb_item(it);
    if (present || eom) data_items++;
    else noop_items++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_message(int len);
    bit tail_byte;
    int body;
    tail_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    body = tail_byte ? len - 1 : len;
    for (int i = 0; i < body; i++) begin
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, 1'b0);
    end
    send_item(8'($urandom), tail_byte, 1'b1);
  endtask

  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) digests.check_word(out_item);
      if (hold_req && hold_left == 0) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    input_stall_cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
      if (in_valid && in_stall === 1'b1) input_stall_cycles++;
    end
    $display("Timed out after %0d cycles with %0d digest words outstanding.",
             cycles, digests.pending());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int target;
    bit pressure_done;
    pressure_done = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ignored items, the empty message, byte and end in one item, "abc".
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item("a", 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item("c", 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);

    target = data_items + RANDOM_ITEMS;
    while (data_items < target) begin
      if (!pressure_done && data_items > target - RANDOM_ITEMS / 2) begin
        // The sink holds off long enough for the core to back up onto its input.
        pressure_done = 1'b1;
        hold_req = 1'b1;
        send_message(3);
        send_message(0);
        send_message(6);
        in_valid <= 1'b0;
        while (digests.pending() != 0) @(posedge clk);
      end
      no_idle = ($urandom_range(0, 4) == 0);
      send_message(pick_length());
    end
    in_valid <= 1'b0;

    while (digests.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Hashed %0d messages from %0d data items and %0d ignored items.",
             digests.messages, data_items, noop_items);
    $display("Checked %0d digest words; the input was held off for %0d cycles.",
             digests.checked, input_stall_cycles);
    if (digests.mismatches == 0 && digests.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/sha1sh_pkg.sv
hdl/sha1sh_ctrl.sv
hdl/sha1sh_dp.sv
hdl/sha1_stream_hasher_core.sv
tb/tb_sha1_stream_hasher_core.sv
